FILE: rtl/mctp_pkg.sv
// ---------------------------------------------------------------------------
// mctp_pkg: timer pool shared definitions
// Action, result and channel-state codes plus the controller/datapath
// command and status bundles.
// ---------------------------------------------------------------------------
package mctp_pkg;

  // Hard ceiling on channels: the channel fields are 3 bits wide.
  localparam int MAX_CH = 8;

  // Input actions
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_ALLOC = 3'd1;
  localparam logic [2:0] ACT_FREE  = 3'd2;
  localparam logic [2:0] ACT_SET   = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_OK      = 2'd0;
  localparam logic [1:0] KIND_REFUSED = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;

  // Channel states
  localparam logic [1:0] CH_UNUSED  = 2'd0;
  localparam logic [1:0] CH_STOPPED = 2'd1;
  localparam logic [1:0] CH_RUNNING = 2'd2;

  localparam logic [15:0] MS_PER_TICK_RST = 16'd10;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // latch the accepted transaction
    logic exec;   // execute a single-result action
    logic scan;   // one channel step of a tick walk
    logic flush;  // drain the held expiry as the final result
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic slot_free;   // output register can take a result this cycle
    logic step_ok;     // current scan step can complete
    logic scan_last;   // scan pointer sits on the last channel
    logic pend_valid;  // an expiry result is being held back
  } dp_sts_t;

endpackage

FILE: rtl/mctp_ctrl.sv
// ---------------------------------------------------------------------------
// mctp_ctrl: timer pool sequencer
// One-hot FSM: accept, execute or walk channels, drain held expiry.
// ---------------------------------------------------------------------------
module mctp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_action,
  output logic              in_stall,
  input  mctp_pkg::dp_sts_t sts,
  output mctp_pkg::dp_cmd_t cmd
);
  import mctp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_action == ACT_TICK) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.step_ok && sts.scan_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (!sts.pend_valid || sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/mctp_dp.sv
// ---------------------------------------------------------------------------
// mctp_dp: timer pool datapath
// Channel registers, tick subtractor, held expiry and output register.
// ---------------------------------------------------------------------------
module mctp_dp #(
  parameter int TIMER_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic [2:0]         in_action,
  input  logic [2:0]         in_timer_index,
  input  logic [30:0]        in_duration_ms,
  input  logic               in_periodic,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [2:0]         out_channel,
  output logic signed [31:0] out_time_left,
  output logic               out_final_item,
  input  mctp_pkg::dp_cmd_t  cmd,
  output mctp_pkg::dp_sts_t  sts
);
  import mctp_pkg::*;

  localparam int NCH  = (TIMER_COUNT < MAX_CH) ? TIMER_COUNT : MAX_CH;
  localparam int CH_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [3:0]      NCH_L  = 4'(NCH);
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NCH - 1);

  // Channel state
  logic [1:0]         state_r  [NCH];
  logic [1:0]         state_nxt[NCH];
  logic               mode_r   [NCH];
  logic               mode_nxt [NCH];
  logic signed [31:0] rem_r    [NCH];
  logic signed [31:0] rem_nxt  [NCH];
  logic [30:0]        reload_r [NCH];
  logic [30:0]        reload_nxt[NCH];

  logic [15:0] mpt_r, mpt_nxt;

  // Latched transaction
  logic [2:0]  act_r, act_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [30:0] dur_r, dur_nxt;
  logic        per_r, per_nxt;

  // Tick walk
  logic [CH_W-1:0]    cnt_r, cnt_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [2:0]         pend_ch_r, pend_ch_nxt;
  logic signed [31:0] pend_tl_r, pend_tl_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [2:0]         out_ch_r, out_ch_nxt;
  logic signed [31:0] out_tl_r, out_tl_nxt;
  logic               out_fin_r, out_fin_nxt;

  logic               slot_free;
  logic [CH_W-1:0]    rd_addr;
  logic [1:0]         rd_state;
  logic signed [31:0] rd_rem;
  logic [30:0]        rd_reload;
  logic               rd_mode;
  logic               idx_ok;
  logic               in_use;
  logic signed [32:0] diff;
  logic signed [31:0] sat;
  logic               expire;
  logic               running;
  logic               free_found;
  logic [CH_W-1:0]    free_idx;

  assign slot_free = !out_valid_r || !out_stall;

  // Single read port: scan pointer during a tick, addressed channel otherwise
  assign rd_addr   = cmd.scan ? cnt_r : idx_r[CH_W-1:0];
  assign rd_state  = state_r[rd_addr];
  assign rd_rem    = rem_r[rd_addr];
  assign rd_reload = reload_r[rd_addr];
  assign rd_mode   = mode_r[rd_addr];

  assign idx_ok  = {1'b0, idx_r} < NCH_L;
  assign in_use  = idx_ok && (rd_state != CH_UNUSED);
  assign running = (rd_state == CH_RUNNING);

  // Tick subtract, saturating at the most negative 32-bit value
  assign diff   = {rd_rem[31], rd_rem} - $signed({17'd0, mpt_r});
  assign expire = diff[32];
  assign sat    = (diff[32] != diff[31]) ? 32'sh8000_0000 : diff[31:0];

  // Lowest unused channel
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NCH - 1; i >= 0; i--) begin
      if (state_r[i] == CH_UNUSED) begin
        free_found = 1'b1;
        free_idx   = CH_W'(i);
      end
    end
  end

  assign sts.slot_free  = slot_free;
  assign sts.step_ok    = !(running && expire && pend_valid_r) || slot_free;
  assign sts.scan_last  = (cnt_r == LAST_CH);
  assign sts.pend_valid = pend_valid_r;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    rem_nxt        = rem_r;
    reload_nxt     = reload_r;
    mpt_nxt        = cfg_wr_en ? cfg_wr_data : mpt_r;
    act_nxt        = act_r;
    idx_nxt        = idx_r;
    dur_nxt        = dur_r;
    per_nxt        = per_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_ch_nxt    = pend_ch_r;
    pend_tl_nxt    = pend_tl_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_ch_nxt     = out_ch_r;
    out_tl_nxt     = out_tl_r;
    out_fin_nxt    = out_fin_r;

    if (cmd.load) begin
      act_nxt        = in_action;
      idx_nxt        = in_timer_index;
      dur_nxt        = in_duration_ms;
      per_nxt        = in_periodic;
      cnt_nxt        = '0;
      pend_valid_nxt = 1'b0;
    end

    if (cmd.exec && slot_free) begin
      out_valid_nxt = 1'b1;
      out_fin_nxt   = 1'b1;
      out_tl_nxt    = '0;
      out_ch_nxt    = idx_r;
      out_kind_nxt  = in_use ? KIND_OK : KIND_REFUSED;
      case (act_r)
        ACT_ALLOC: begin
          if (free_found) begin
            state_nxt[free_idx] = CH_STOPPED;
            rem_nxt[free_idx]   = '0;
            out_kind_nxt        = KIND_OK;
            out_ch_nxt          = 3'(free_idx);
          end else begin
            out_kind_nxt = KIND_REFUSED;
            out_ch_nxt   = '0;
          end
        end
        ACT_FREE: begin
          if (in_use) begin
            state_nxt[rd_addr] = CH_UNUSED;
          end
        end
        ACT_SET: begin
          if (in_use) begin
            reload_nxt[rd_addr] = dur_r;
            rem_nxt[rd_addr]    = $signed({1'b0, dur_r});
            mode_nxt[rd_addr]   = per_r;
            state_nxt[rd_addr]  = CH_RUNNING;
          end
        end
        ACT_STOP: begin
          if (in_use) begin
            state_nxt[rd_addr] = CH_STOPPED;
          end
        end
        ACT_READ: begin
          if (in_use) begin
            out_tl_nxt = rd_rem;
          end
        end
        default: begin
          out_kind_nxt = KIND_REFUSED;
        end
      endcase
    end

    if (cmd.scan && sts.step_ok) begin
      if (running) begin
        rem_nxt[rd_addr] = sat;
        if (expire) begin
          if (rd_mode) begin
            rem_nxt[rd_addr] = $signed({1'b0, rd_reload});
          end else begin
            state_nxt[rd_addr] = CH_STOPPED;
          end
          // Previous expiry is known not to be last: push it out
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_EXPIRED;
            out_ch_nxt    = pend_ch_r;
            out_tl_nxt    = pend_tl_r;
            out_fin_nxt   = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_ch_nxt    = 3'(cnt_r);
          pend_tl_nxt    = sat;
        end
      end
      if (!sts.scan_last) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    if (cmd.flush && pend_valid_r && slot_free) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_EXPIRED;
      out_ch_nxt     = pend_ch_r;
      out_tl_nxt     = pend_tl_r;
      out_fin_nxt    = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        state_r[i] <= CH_UNUSED;
      end
      mpt_r        <= MS_PER_TICK_RST;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      mpt_r        <= mpt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    rem_r      <= rem_nxt;
    reload_r   <= reload_nxt;
    act_r      <= act_nxt;
    idx_r      <= idx_nxt;
    dur_r      <= dur_nxt;
    per_r      <= per_nxt;
    pend_ch_r  <= pend_ch_nxt;
    pend_tl_r  <= pend_tl_nxt;
    out_kind_r <= out_kind_nxt;
    out_ch_r   <= out_ch_nxt;
    out_tl_r   <= out_tl_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_channel    = out_ch_r;
  assign out_time_left  = out_tl_r;
  assign out_final_item = out_fin_r;

endmodule

FILE: rtl/multi_channel_timer_pool.sv
// ---------------------------------------------------------------------------
// multi_channel_timer_pool: pool of millisecond one-shot/periodic timers
// Channels are allocated, set, stopped, read and freed by transactions;
// a tick transaction counts every running channel down.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall): one action per transaction. The
//    block takes one transaction at a time; in_stall is high while it is
//    busy with the previous one.
//  - Result channel (out_valid/out_stall): every non-tick action yields one
//    result; a tick yields one expiry per expired channel in index order,
//    or none. out_final_item marks the last result of a transaction.
//  - cfg_wr_en/cfg_wr_data load ms_per_tick; write only while idle.
//  - Timing: a non-tick transaction is latched at accept and executed once
//    the output register is free; its result is registered and the input
//    reopens in that same cycle. A tick walks the channels one per cycle
//    through a single read port (pausing while a second expiry waits on a
//    stalled output), then drains the held expiry in a flush state before
//    the input reopens. The last expiry of a tick is held until the walk
//    ends so its final flag is known.
//  - Receiver stall: the output register holds its transaction; the walk
//    pauses only when it has a second expiry to hand over.
//  - Reset (rst_n low, synchronous): all channels unused, ms_per_tick 10,
//    no result pending.
// ---------------------------------------------------------------------------
module multi_channel_timer_pool #(
  parameter int TIMER_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [2:0]         in_timer_index,
  input  logic [30:0]        in_duration_ms,
  input  logic               in_periodic,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [2:0]         out_channel,
  output logic signed [31:0] out_time_left,
  output logic               out_final_item
);
  import mctp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: decides which datapath operation runs each cycle
  mctp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Channel storage, subtractor and output register
  mctp_dp #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_action      (in_action),
    .in_timer_index (in_timer_index),
    .in_duration_ms (in_duration_ms),
    .in_periodic    (in_periodic),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_channel    (out_channel),
    .out_time_left  (out_time_left),
    .out_final_item (out_final_item),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

FILE: rtl/mctp_chk.sv
// ---------------------------------------------------------------------------
// mctp_chk: timer pool port checker
// Port-level properties of the timer pool, bound to the top level.
// ---------------------------------------------------------------------------
module mctp_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_kind,
  input logic [2:0]         out_channel,
  input logic signed [31:0] out_time_left,
  input logic               out_final_item
);
  import mctp_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_channel) && $stable(out_time_left) && $stable(out_final_item))
    else $error("stalled result changed");

  // One transaction at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind != 2'd3)
    else $error("bad result kind");

  // Only ticks give more than one result
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_EXPIRED |-> out_final_item)
    else $error("non-expiry result not final");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REFUSED |-> out_time_left == 32'sd0)
    else $error("refused result carries time");

endmodule

bind multi_channel_timer_pool mctp_chk u_mctp_chk (.*);

FILE: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for multi_channel_timer_pool
// A directed pass (reset state, refusals, pool exhaustion, tick extremes)
// followed by constrained-by-hand random traffic over several tick lengths.
// Every accepted transaction is run through an in-bench timer pool model;
// results are matched in order, field by field.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mctp_pkg::*;

  localparam int         N_CH            = 8;
  // Actions 6 and 7 have no meaning; the block must refuse them.
  localparam logic [2:0] ACT_BAD6        = 3'd6;
  localparam logic [2:0] ACT_BAD7        = 3'd7;
  // A silent tick walk can outlast the last result; leave margin before a cfg write.
  localparam int         SETTLE_CYCLES   = 16;
  localparam int         N_PHASES        = 5;
  localparam int         ITEMS_PER_PHASE = 52;
  localparam int         N_DIRECTED      = 26;
  localparam int         LIMIT_NS        = 2_000_000;
  localparam longint     INT32_FLOOR     = -64'sd2147483648;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         channel;
    logic signed [31:0] time_left;
    logic               final_item;
  } timer_result_t;

  // One directed transaction. has_ref marks rows whose single result is
  // obvious enough to be typed in (time_left 0, final flag set).
  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  idx;
    logic [30:0] dur;
    logic        per;
    logic        has_ref;
    logic [1:0]  ref_kind;
    logic [2:0]  ref_channel;
  } stim_row_t;

  // -------------------------------------------------------------------------
  // DUT hookup
  // -------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [15:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_action;
  logic [2:0]         in_timer_index;
  logic [30:0]        in_duration_ms;
  logic               in_periodic;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_kind;
  logic [2:0]         out_channel;
  logic signed [31:0] out_time_left;
  logic               out_final_item;

  always #1 clk = ~clk;

  multi_channel_timer_pool #(
    .TIMER_COUNT(N_CH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_timer_index (in_timer_index),
    .in_duration_ms (in_duration_ms),
    .in_periodic    (in_periodic),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_channel    (out_channel),
    .out_time_left  (out_time_left),
    .out_final_item (out_final_item)
  );

  // -------------------------------------------------------------------------
  // Bench-side copy of the pool: updated at the edge a transaction is taken
  // -------------------------------------------------------------------------
  logic [15:0]        tick_ms;
  logic [1:0]         chan_state    [N_CH];
  logic               chan_periodic [N_CH];
  logic signed [31:0] chan_left     [N_CH];
  logic [30:0]        chan_reload   [N_CH];

  timer_result_t expected_results [$];
  int            mismatch_count = 0;
  int            burst_left     = 0;

  // Receiver stall pattern: style and run length redrawn every stretch
  int            stall_left  = 0;
  int            stall_style = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // nothing allocated yet: every addressed action is refused
    '{ACT_READ,  3'd0, 31'd0,          1'b0, 1'b1, KIND_REFUSED, 3'd0},
    '{ACT_FREE,  3'd7, 31'd0,          1'b0, 1'b1, KIND_REFUSED, 3'd7},
    '{ACT_STOP,  3'd3, 31'd0,          1'b0, 1'b1, KIND_REFUSED, 3'd3},
    '{ACT_SET,   3'd5, 31'h7FFF_FFFF,  1'b1, 1'b1, KIND_REFUSED, 3'd5},
    '{ACT_TICK,  3'd0, 31'd0,          1'b0, 1'b0, KIND_OK,      3'd0},
    '{ACT_BAD6,  3'd2, 31'd0,          1'b0, 1'b1, KIND_REFUSED, 3'd2},
    '{ACT_BAD7,  3'd7, 31'h7FFF_FFFF,  1'b1, 1'b1, KIND_REFUSED, 3'd7},
    // fill the pool, lowest channel first, then one allocate too many
    '{ACT_ALLOC, 3'd7, 31'd0,          1'b0, 1'b1, KIND_OK,      3'd0},
    '{ACT_ALLOC, 3'd0, 31'd0,          1'b0, 1'b1, KIND_OK,      3'd1},
    '{ACT_ALLOC, 3'd0, 31'd0,          1'b0, 1'b1, KIND_OK,      3'd2},
    '{ACT_ALLOC, 3'd0, 31'd0,          1'b0, 1'b1, KIND_OK,      3'd3},
    '{ACT_ALLOC, 3'd0, 31'd0,          1'b0, 1'b1, KIND_OK,      3'd4},
    '{ACT_ALLOC, 3'd0, 31'd0,          1'b0, 1'b1, KIND_OK,      3'd5},
    '{ACT_ALLOC, 3'd0, 31'd0,          1'b0, 1'b1, KIND_OK,      3'd6},
    '{ACT_ALLOC, 3'd0, 31'd0,          1'b0, 1'b1, KIND_OK,      3'd7},
    '{ACT_ALLOC, 3'd5, 31'd0,          1'b0, 1'b1, KIND_REFUSED, 3'd0},
    // longest duration, zero-duration periodic, short one-shot
    '{ACT_SET,   3'd0, 31'h7FFF_FFFF,  1'b1, 1'b1, KIND_OK,      3'd0},
    '{ACT_SET,   3'd1, 31'd0,          1'b1, 1'b1, KIND_OK,      3'd1},
    '{ACT_SET,   3'd2, 31'd5,          1'b0, 1'b1, KIND_OK,      3'd2},
    '{ACT_TICK,  3'd0, 31'd0,          1'b0, 1'b0, KIND_OK,      3'd0},
    // one-shot has stopped below zero; read shows the negative value
    '{ACT_READ,  3'd2, 31'd0,          1'b0, 1'b0, KIND_OK,      3'd0},
    // free then re-allocate: the freed channel is the lowest unused one
    '{ACT_FREE,  3'd2, 31'd0,          1'b0, 1'b1, KIND_OK,      3'd2},
    '{ACT_ALLOC, 3'd0, 31'd0,          1'b0, 1'b1, KIND_OK,      3'd2},
    '{ACT_READ,  3'd0, 31'd0,          1'b0, 1'b0, KIND_OK,      3'd0},
    '{ACT_STOP,  3'd1, 31'd0,          1'b0, 1'b1, KIND_OK,      3'd1},
    '{ACT_TICK,  3'd0, 31'd0,          1'b0, 1'b0, KIND_OK,      3'd0}
  };

  function automatic timer_result_t mk_result(logic [1:0] kind, logic [2:0] ch,
                                              logic signed [31:0] t, logic fin);
    timer_result_t r;
    r.kind       = kind;
    r.channel    = ch;
    r.time_left  = t;
    r.final_item = fin;
    return r;
  endfunction

  // Timer pool model: applies one transaction, queues the results it causes.
  function automatic void predict_timer_results(logic [2:0] act, logic [2:0] idx,
                                                logic [30:0] dur, logic per);
    longint        diff;
    timer_result_t held;
    bit            have_held;
    bit            used;

    have_held = 1'b0;
    used      = (chan_state[idx] != CH_UNUSED);
    held      = mk_result(KIND_REFUSED, idx, 32'sd0, 1'b1);
    case (act)
      ACT_TICK: begin
        // Last expiry is held back so its final flag can be set.
        for (int i = 0; i < N_CH; i++) begin
          if (chan_state[i] == CH_RUNNING) begin
            diff = longint'(chan_left[i]) - longint'(tick_ms);
            if (diff < INT32_FLOOR) diff = INT32_FLOOR;
            chan_left[i] = diff[31:0];
            if (diff < 0) begin
              if (have_held) expected_results.push_back(held);
              held      = mk_result(KIND_EXPIRED, i[2:0], diff[31:0], 1'b0);
              have_held = 1'b1;
              if (chan_periodic[i]) chan_left[i] = {1'b0, chan_reload[i]};
              else chan_state[i] = CH_STOPPED;
            end
          end
        end
        if (have_held) begin
          held.final_item = 1'b1;
          expected_results.push_back(held);
        end
      end
      ACT_ALLOC: begin
        held = mk_result(KIND_REFUSED, 3'd0, 32'sd0, 1'b1);
        for (int i = 0; i < N_CH; i++) begin
          if (!have_held && chan_state[i] == CH_UNUSED) begin
            chan_state[i] = CH_STOPPED;
            chan_left[i]  = 32'sd0;
            held          = mk_result(KIND_OK, i[2:0], 32'sd0, 1'b1);
            have_held     = 1'b1;
          end
        end
        expected_results.push_back(held);
      end
      ACT_FREE, ACT_SET, ACT_STOP, ACT_READ: begin
        if (used) begin
          held = mk_result(KIND_OK, idx, 32'sd0, 1'b1);
          case (act)
            ACT_FREE: chan_state[idx] = CH_UNUSED;
            ACT_SET: begin
              chan_reload[idx]   = dur;
              chan_left[idx]     = {1'b0, dur};
              chan_periodic[idx] = per;
              chan_state[idx]    = CH_RUNNING;
            end
            ACT_STOP: chan_state[idx] = CH_STOPPED;
            default:  held.time_left = chan_left[idx];
          endcase
        end
        expected_results.push_back(held);
      end
      default: expected_results.push_back(held);
    endcase
  endfunction

  // Sender: bursts of back-to-back transactions separated by random gaps.
  // Returns at the edge where the transaction was taken.
  task automatic send_action(logic [2:0] act, logic [2:0] idx, logic [30:0] dur,
                             logic per);
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_timer_index <= idx;
    in_duration_ms <= dur;
    in_periodic    <= per;
    do @(posedge clk); while (in_stall);
  endtask

  // Wait until every expected result is out and any silent tick walk is over.
  task automatic drain_results();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_length(logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tick_ms      = value;
  endtask

  // Mostly legal traffic on live channels; some refusals and junk actions.
  task automatic random_item();
    int          pick;
    int          used_list [$];
    logic [2:0]  act;
    logic [2:0]  idx;
    logic [30:0] dur;
    logic        per;
    int unsigned span;

    for (int c = 0; c < N_CH; c++)
      if (chan_state[c] != CH_UNUSED) used_list.push_back(c);
    pick = $urandom_range(0, 99);
    if (pick < 30)      act = ACT_TICK;
    else if (pick < 44) act = ACT_SET;
    else if (pick < 54) act = ACT_READ;
    else if (pick < 62) act = ACT_STOP;
    else if (pick < 70) act = ACT_FREE;
    else if (pick < 84) act = ACT_ALLOC;
    else if (pick < 90) act = $urandom_range(0, 1) ? ACT_BAD6 : ACT_BAD7;
    else                act = $urandom_range(0, 1) ? ACT_SET : ACT_READ;

    // Noise rows (pick >= 90) address any channel, used or not.
    if (pick < 90 && used_list.size() != 0 && $urandom_range(0, 99) < 85)
      idx = 3'(used_list[$urandom_range(0, used_list.size() - 1)]);
    else
      idx = 3'($urandom_range(0, N_CH - 1));

    // Durations scaled to the tick so that expiries happen regularly.
    span = (tick_ms == 16'd0) ? 64 : 4 * tick_ms;
    case ($urandom_range(0, 19))
      0:       dur = 31'($urandom);
      1:       dur = 31'd0;
      default: dur = 31'($urandom_range(0, span));
    endcase
    per = 1'($urandom_range(0, 1));

    send_action(act, idx, dur, per);
    predict_timer_results(act, idx, dur, per);
  endtask

  // -------------------------------------------------------------------------
  // Receiver: stall pattern changes style whenever its random run length runs out
  //   0: never stall, 1: coin flip, 2: mostly stalled, 3: square wave
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(20, 80);
    end else begin
      stall_left  <= stall_left - 1;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[2];
    endcase
  end

  // -------------------------------------------------------------------------
  // Result checker: every taken result transaction against the oldest
  // expectation
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d channel %0d",
                 $time, out_kind, out_channel);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_kind);
          mismatch_count++;
        end
        if (out_channel !== want.channel) begin
          $display("%0t: channel expected %0d actual %0d",
                   $time, want.channel, out_channel);
          mismatch_count++;
        end
        if (out_time_left !== want.time_left) begin
          $display("%0t: time_left expected %0d actual %0d",
                   $time, want.time_left, out_time_left);
          mismatch_count++;
        end
        if (out_final_item !== want.final_item) begin
          $display("%0t: final_item expected %0b actual %0b",
                   $time, want.final_item, out_final_item);
          mismatch_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned phase_ticks [N_PHASES];
    stim_row_t   row;

    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 16'd0;
    in_valid       = 1'b0;
    in_action      = ACT_TICK;
    in_timer_index = 3'd0;
    in_duration_ms = 31'd0;
    in_periodic    = 1'b0;

    tick_ms = MS_PER_TICK_RST;
    for (int c = 0; c < N_CH; c++) begin
      chan_state[c]    = CH_UNUSED;
      chan_periodic[c] = 1'b0;
      chan_left[c]     = 32'sd0;
      chan_reload[c]   = 31'd0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass at the reset tick length. Typed rows replace the
    // model's answer so the DUT gets checked against hand-typed values there.
    for (int r = 0; r < N_DIRECTED; r++) begin
      row = directed_rows[r];
      send_action(row.action, row.idx, row.dur, row.per);
      predict_timer_results(row.action, row.idx, row.dur, row.per);
      if (row.has_ref) begin
        void'(expected_results.pop_back());
        expected_results.push_back(mk_result(row.ref_kind, row.ref_channel,
                                             32'sd0, 1'b1));
      end
    end

    // Random phases: shortest tick, longest tick, frozen, arbitrary, default.
    phase_ticks    = '{1, 65535, 0, 0, 10};
    phase_ticks[3] = $urandom_range(2, 65534);
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_tick_length(phase_ticks[p][15:0]);
      repeat (ITEMS_PER_PHASE) random_item();
    end

    drain_results();
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Hang guard: far beyond the slowest legal run
  initial begin
    #(LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: multi_channel_timer_pool.f
rtl/mctp_pkg.sv
rtl/mctp_ctrl.sv
rtl/mctp_dp.sv
rtl/multi_channel_timer_pool.sv
rtl/mctp_chk.sv
bench/tb_top.sv
